### hw/rtl/crs_pkg.sv
// Shared types, constants and codes for the clip rectangle stack.
package crs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int EXT_W       = 18;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } crs_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_RD
  } crs_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
  } crs_in_t;

  typedef struct packed {
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [14:0]        clip_w;
    logic [14:0]        clip_h;
    logic               clip_on;
    logic               overflow;
  } crs_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } crs_rect_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic push;
    logic push_ovf;
    logic pop_off;
    logic pop_rd;
    logic pop_load;
    logic clear;
  } crs_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       empty;
    logic       one;
    logic       full;
  } crs_sts_t;

endpackage

### hw/rtl/crs_ctrl.sv
// Controller state machine sequencing each command through the datapath.
module crs_ctrl import crs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  crs_sts_t sts,
  output crs_ctl_t ctl
);

  crs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (sts.command)
          CMD_PUSH: begin
            if (sts.full) ctl.push_ovf = 1'b1;
            else          ctl.push     = 1'b1;
          end
          CMD_POP: begin
            if (sts.one) begin
              ctl.pop_off = 1'b1;
            end else if (!sts.empty) begin
              // fetch the entry beneath the top
              ctl.pop_rd = 1'b1;
              state_nxt  = ST_POP_RD;
            end
          end
          CMD_CLEAR: ctl.clear = 1'b1;
          default: ;
        endcase
      end
      ST_POP_RD: begin
        ctl.pop_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/crs_dp.sv
// Datapath: command register, top-of-stack register, stack memory and result register.
module crs_dp import crs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  crs_in_t  in_data,
  input  crs_ctl_t ctl,
  output crs_sts_t sts,
  output logic     out_valid,
  output crs_out_t out_data
);

  crs_in_t            in_r;
  crs_rect_t          top_r, top_nxt;
  crs_rect_t          rd_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  crs_out_t           out_r, out_nxt;
  crs_rect_t          mem [STACK_DEPTH];

  logic [CNT_W-1:0]   cnt_m2;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;

  logic signed [EXT_W-1:0] px, py, bx, by, pr, pb, br, bb;
  logic signed [EXT_W-1:0] x0, x1, y0, y1, dw, dh;
  crs_rect_t               isect, push_val;

  assign sts.command = in_r.command;
  assign sts.empty   = (count_r == '0);
  assign sts.one     = (count_r == CNT_W'(1));
  assign sts.full    = (count_r >= CNT_W'(STACK_DEPTH));

  assign cnt_m2  = count_r - CNT_W'(2);
  assign rd_addr = cnt_m2[PTR_W-1:0];
  assign wr_addr = count_r[PTR_W-1:0];

  // intersection of the incoming box with the current top
  always_comb begin
    px = EXT_W'(top_r.x);
    py = EXT_W'(top_r.y);
    bx = EXT_W'(in_r.box_x);
    by = EXT_W'(in_r.box_y);
    pr = px + $signed({{(EXT_W-15){1'b0}}, top_r.w});
    pb = py + $signed({{(EXT_W-15){1'b0}}, top_r.h});
    br = bx + $signed({{(EXT_W-15){1'b0}}, in_r.box_w});
    bb = by + $signed({{(EXT_W-15){1'b0}}, in_r.box_h});
    x0 = (px > bx) ? px : bx;
    y0 = (py > by) ? py : by;
    x1 = (pr < br) ? pr : br;
    y1 = (pb < bb) ? pb : bb;
    dw = x1 - x0;
    dh = y1 - y0;
    if (dw < EXT_W'(1) || dh < EXT_W'(1)) begin
      isect = '0;
    end else begin
      isect.x = x0[15:0];
      isect.y = y0[15:0];
      isect.w = dw[14:0];
      isect.h = dh[14:0];
    end
  end

  always_comb begin
    if (count_r == '0) begin
      push_val.x = in_r.box_x;
      push_val.y = in_r.box_y;
      push_val.w = in_r.box_w;
      push_val.h = in_r.box_h;
    end else begin
      push_val = isect;
    end
  end

  always_comb begin
    top_nxt       = top_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (ctl.push) begin
      top_nxt       = push_val;
      count_nxt     = count_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
      out_nxt       = {push_val.x, push_val.y, push_val.w, push_val.h, 1'b1, 1'b0};
    end
    if (ctl.push_ovf) begin
      // drop the box, report the unchanged top
      out_valid_nxt = 1'b1;
      out_nxt       = {top_r.x, top_r.y, top_r.w, top_r.h, 1'b1, 1'b1};
    end
    if (ctl.pop_off) begin
      count_nxt     = '0;
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
    end
    if (ctl.pop_rd) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (ctl.pop_load) begin
      top_nxt       = rd_r;
      out_valid_nxt = 1'b1;
      out_nxt       = {rd_r.x, rd_r.y, rd_r.w, rd_r.h, 1'b1, 1'b0};
    end
    if (ctl.clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) in_r <= in_data;
    top_r <= top_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr_addr] <= push_val;
  end

  always_ff @(posedge clk) begin
    if (ctl.pop_rd) rd_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push_ovf |-> count_r == CNT_W'(STACK_DEPTH))
    else $error("push dropped while stack not full");

  a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.clip_on) |-> (out_r.clip_w == '0 && out_r.clip_h == '0
      && !out_r.overflow && count_r == '0))
    else $error("clipping off reported with non-empty state");

endmodule

### hw/rtl/clip_rect_stack_top.sv
// Top level of the nested clip rectangle stack.
//
// Input: present a command on in_data with start high; it is taken at the
// clock edge where start is high and busy is low. Commands are push box,
// pop top entry and clear stack.
// Output: each result sits on out_data for exactly one cycle with
// out_valid high; the receiver has no way to hold it off.
// Push: one result, passed through the command register and then the result
// register (intersected box, or the unchanged top with overflow set when
// full); busy only in the execute state. Pop: the same path when the stack
// empties; an older entry read back from the stack memory passes its
// registered read port first; no result on an empty stack.
// Clear and the unused code give no result and keep busy for one cycle.
// The next command is taken once busy falls, after the execute state and,
// for a pop that leaves entries behind, the pop read state.
// Reset empties the stack at once; memory contents are not cleared.
module clip_rect_stack_top import crs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  crs_in_t  in_data,
  output logic     out_valid,
  output crs_out_t out_data
);

  crs_ctl_t ctl;
  crs_sts_t sts;

  crs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  crs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### tb/clip_rect_stack_top_test.sv
// Self-checking testbench for the clip rectangle stack: queued command driver, result monitor.
`timescale 1ns / 1ps

module clip_rect_stack_top_test;
  import crs_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         RANDOM_ITEMS = 1900;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     start    = 1'b0;
  crs_in_t  in_data  = '0;
  logic     busy;
  logic     out_valid;
  crs_out_t out_data;

  crs_in_t   pending_cmds[$];
  crs_out_t  clip_expect_q[$];
  crs_rect_t clip_model[STACK_DEPTH];
  int        clip_depth = 0;
  int        send_idle_pct = 13;
  int        cycle_count = 0;
  bit        failed = 1'b0;

  clip_rect_stack_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic crs_in_t make_cmd(logic [1:0] cmd, int x, int y, int w, int h);
    crs_in_t c;
    c.command = cmd;
    c.box_x   = 16'(x);
    c.box_y   = 16'(y);
    c.box_w   = 15'(w);
    c.box_h   = 15'(h);
    return c;
  endfunction

  function automatic crs_in_t random_cmd(int push_pct);
    crs_in_t c;
    int      roll;
    roll = $urandom_range(99);
    if (roll < push_pct) c.command = CMD_PUSH;
    else if (roll < 94) c.command = CMD_POP;
    else if (roll < 97) c.command = CMD_CLEAR;
    else c.command = CMD_UNUSED;
    if ($urandom_range(4) == 0) begin
      c.box_x = 16'($urandom);
      c.box_y = 16'($urandom);
      c.box_w = 15'($urandom);
      c.box_h = 15'($urandom);
    end else begin
      // keep boxes near the origin so nested pushes mostly overlap
      c.box_x = 16'(int'($urandom_range(256)) - 128);
      c.box_y = 16'(int'($urandom_range(256)) - 128);
      c.box_w = 15'($urandom_range(200));
      c.box_h = 15'($urandom_range(200));
    end
    return c;
  endfunction

  // Update the shadow stack for one accepted command and queue the clip it reports.
  function automatic void track_clip_stack(crs_in_t item);
    crs_out_t  res;
    crs_rect_t top;
    crs_rect_t fresh;
    int        lo_x, hi_x, lo_y, hi_y;
    res = '0;
    case (item.command)
      CMD_PUSH: begin
        if (clip_depth == STACK_DEPTH) begin
          res = {clip_model[STACK_DEPTH-1], 1'b1, 1'b1};
        end else begin
          if (clip_depth == 0) begin
            fresh = {item.box_x, item.box_y, item.box_w, item.box_h};
          end else begin
            top  = clip_model[clip_depth-1];
            lo_x = int'(top.x) > int'(item.box_x) ? int'(top.x) : int'(item.box_x);
            lo_y = int'(top.y) > int'(item.box_y) ? int'(top.y) : int'(item.box_y);
            hi_x = (int'(top.x) + int'(top.w)) < (int'(item.box_x) + int'(item.box_w)) ?
                   (int'(top.x) + int'(top.w)) : (int'(item.box_x) + int'(item.box_w));
            hi_y = (int'(top.y) + int'(top.h)) < (int'(item.box_y) + int'(item.box_h)) ?
                   (int'(top.y) + int'(top.h)) : (int'(item.box_y) + int'(item.box_h));
            if (hi_x - lo_x < 1 || hi_y - lo_y < 1) begin
              fresh = '0;
            end else begin
              fresh.x = 16'(lo_x);
              fresh.y = 16'(lo_y);
              fresh.w = 15'(hi_x - lo_x);
              fresh.h = 15'(hi_y - lo_y);
            end
          end
          clip_model[clip_depth] = fresh;
          clip_depth++;
          res = {fresh, 1'b1, 1'b0};
        end
      end
      CMD_POP: begin
        if (clip_depth == 0) return;
        clip_depth--;
        if (clip_depth != 0) res = {clip_model[clip_depth-1], 1'b1, 1'b0};
      end
      CMD_CLEAR: begin
        clip_depth = 0;
        return;
      end
      default: return;
    endcase
    clip_expect_q.push_back(res);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Driver: note the transfer at this edge, then offer the next command or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) track_clip_stack(in_data);
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_cmds.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    crs_out_t want;
    if (rst_n && out_valid) begin
      if (clip_expect_q.size() == 0) begin
        $error("result with no command outstanding: %h", out_data);
        failed = 1'b1;
      end else begin
        want = clip_expect_q.pop_front();
        check_field("clip_x",   want.clip_x,   out_data.clip_x);
        check_field("clip_y",   want.clip_y,   out_data.clip_y);
        check_field("clip_w",   want.clip_w,   out_data.clip_w);
        check_field("clip_h",   want.clip_h,   out_data.clip_h);
        check_field("clip_on",  want.clip_on,  out_data.clip_on);
        check_field("overflow", want.overflow, out_data.overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int push_pct;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty-stack cases and the unused code
    pending_cmds.push_back(make_cmd(CMD_POP, 5, 5, 5, 5));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, -1, -1, 32767, 32767));
    // extremes, then a disjoint push and a zero-size push
    pending_cmds.push_back(make_cmd(CMD_PUSH, -32768, -32768, 32767, 32767));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 32767, 32767, 32767, 32767));
    pending_cmds.push_back(make_cmd(CMD_POP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PUSH, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_POP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_POP, 0, 0, 0, 0));
    // fill with shrinking nested boxes, then one push past full
    for (int i = 0; i <= STACK_DEPTH; i++)
      pending_cmds.push_back(make_cmd(CMD_PUSH, -100 + i, -90 + 2 * i, 200 - 2 * i, 190 - 3 * i));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
    while (pending_cmds.size() != 0) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 71 : 0;
      push_pct = 45;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        // alternate between filling bursts and balanced stretches
        if (n % 40 == 0) push_pct = ($urandom_range(1) != 0) ? 80 : 45;
        pending_cmds.push_back(random_cmd(push_pct));
      end
      while (pending_cmds.size() != 0) @(posedge clk);
    end

    while (start || clip_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
